// File: hdl/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg
// types, token codes and scan modes shared by the tokenizer modules
// ----------------------------------------------------------------------------
package clt_pkg;

    localparam int KW_COUNT    = 19;
    localparam int OFFSET_BITS = 24;

    // token kinds
    localparam logic [6:0] K_END   = 7'd19;
    localparam logic [6:0] K_INT   = 7'd63;
    localparam logic [6:0] K_CHAR  = 7'd64;
    localparam logic [6:0] K_IDENT = 7'd65;
    localparam logic [6:0] K_ERROR = 7'd66;
    localparam logic [6:0] K_DIVEQ = 7'd38;
    localparam logic [6:0] K_DIV   = 7'd39;

    // error codes
    localparam logic [2:0] E_BAD_CHAR   = 3'd0;
    localparam logic [2:0] E_BAD_ESC    = 3'd1;
    localparam logic [2:0] E_EMPTY      = 3'd2;
    localparam logic [2:0] E_UNTERM     = 3'd3;
    localparam logic [2:0] E_OVERFLOW   = 3'd4;

    // scan modes
    localparam logic [3:0] M_IDLE       = 4'd0;
    localparam logic [3:0] M_OPER       = 4'd1;
    localparam logic [3:0] M_SLASH      = 4'd2;
    localparam logic [3:0] M_LINE       = 4'd3;
    localparam logic [3:0] M_BLOCK      = 4'd4;
    localparam logic [3:0] M_BLOCK_STAR = 4'd5;
    localparam logic [3:0] M_ZERO       = 4'd6;
    localparam logic [3:0] M_DEC        = 4'd7;
    localparam logic [3:0] M_HEX        = 4'd8;
    localparam logic [3:0] M_IDENT      = 4'd9;
    localparam logic [3:0] M_CH_OPEN    = 4'd10;
    localparam logic [3:0] M_CH_ESC     = 4'd11;
    localparam logic [3:0] M_CH_CLOSE   = 4'd12;
    localparam logic [3:0] M_HALT       = 4'd13;

    localparam logic [62:0] VALUE_MAX = {63{1'b1}};

    typedef struct packed {
        logic       kind;
        logic [7:0] source_byte;
    } t_in_word;

    typedef struct packed {
        logic [6:0]             token_kind;
        logic [62:0]            token_value;
        logic [15:0]            start_line;
        logic [15:0]            start_column;
        logic [OFFSET_BITS-1:0] start_offset;
        logic [15:0]            lexeme_length;
        logic [2:0]             error_code;
        logic                   last_of_run;
    } t_out_word;

    // operator first byte: kinds alone, doubled, followed by '='
    typedef struct packed {
        logic       is_op;
        logic       has_dbl;
        logic       has_eq;
        logic [6:0] alone;
        logic [6:0] dbl;
        logic [6:0] eq;
    } t_op_info;

    function automatic t_op_info op_kinds(input logic [7:0] c);
        t_op_info r;
        r = '0;
        r.is_op = 1'b1;
        case (c)
            8'h2B: begin r.has_dbl = 1; r.dbl = 7'd30; r.has_eq = 1; r.eq = 7'd31; r.alone = 7'd32; end
            8'h2D: begin r.has_dbl = 1; r.dbl = 7'd33; r.has_eq = 1; r.eq = 7'd34; r.alone = 7'd35; end
            8'h2A: begin r.has_eq = 1; r.eq = 7'd36; r.alone = 7'd37; end
            8'h2F: begin r.has_eq = 1; r.eq = 7'd38; r.alone = 7'd39; end
            8'h25: begin r.has_eq = 1; r.eq = 7'd40; r.alone = 7'd41; end
            8'h26: begin r.has_dbl = 1; r.dbl = 7'd42; r.has_eq = 1; r.eq = 7'd43; r.alone = 7'd44; end
            8'h7C: begin r.has_dbl = 1; r.dbl = 7'd45; r.has_eq = 1; r.eq = 7'd46; r.alone = 7'd47; end
            8'h5E: begin r.has_eq = 1; r.eq = 7'd48; r.alone = 7'd49; end
            8'h21: begin r.has_eq = 1; r.eq = 7'd50; r.alone = 7'd51; end
            8'h3D: begin r.has_eq = 1; r.eq = 7'd52; r.alone = 7'd53; end
            8'h3C: begin r.has_dbl = 1; r.dbl = 7'd54; r.has_eq = 1; r.eq = 7'd55; r.alone = 7'd56; end
            8'h3E: begin r.has_dbl = 1; r.dbl = 7'd57; r.has_eq = 1; r.eq = 7'd58; r.alone = 7'd59; end
            8'h3A: begin r.has_eq = 1; r.eq = 7'd61; r.alone = 7'd62; end
            default: r.is_op = 1'b0;
        endcase
        return r;
    endfunction

    // single-byte operators, bit 7 set when the byte is one
    function automatic logic [7:0] single_op(input logic [7:0] c);
        logic [7:0] r;
        r = 8'h80;
        case (c)
            8'h28: r[6:0] = 7'd20;
            8'h29: r[6:0] = 7'd21;
            8'h7B: r[6:0] = 7'd22;
            8'h7D: r[6:0] = 7'd23;
            8'h3B: r[6:0] = 7'd24;
            8'h2C: r[6:0] = 7'd25;
            8'h23: r[6:0] = 7'd26;
            8'h7E: r[6:0] = 7'd27;
            8'h5B: r[6:0] = 7'd28;
            8'h5D: r[6:0] = 7'd29;
            8'h3F: r[6:0] = 7'd60;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // keyword text, left aligned in 8 bytes, first char in the top byte
    function automatic logic [63:0] kw_text(input int i);
        logic [63:0] r;
        case (i)
            0:  r = {"if",       48'h0};
            1:  r = {"else",     32'h0};
            2:  r = {"while",    24'h0};
            3:  r = {"do",       48'h0};
            4:  r = {"for",      40'h0};
            5:  r = {"return",   16'h0};
            6:  r = {"rt",       48'h0};
            7:  r = {"break",    24'h0};
            8:  r = "continue";
            9:  r = {"goto",     32'h0};
            10: r = "function";
            11: r = {"fn",       48'h0};
            12: r = {"void",     32'h0};
            13: r = {"int",      40'h0};
            14: r = {"char",     32'h0};
            15: r = "unsigned";
            16: r = {"signed",   16'h0};
            17: r = {"nop",      40'h0};
            default: r = {"null", 32'h0};
        endcase
        return r;
    endfunction

    function automatic logic [3:0] kw_len(input int i);
        logic [3:0] r;
        case (i)
            0, 3, 6, 11:          r = 4'd2;
            4, 13, 17:            r = 4'd3;
            1, 9, 12, 14, 18:     r = 4'd4;
            2, 7:                 r = 4'd5;
            5, 16:                r = 4'd6;
            default:              r = 4'd8;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] inc16(input logic [15:0] v);
        return (v != 16'hFFFF) ? v + 16'd1 : v;
    endfunction

endpackage

// File: hdl/clt_front.sv
// ----------------------------------------------------------------------------
// clt_front
// byte classifier: registers the input word with its character class flags
// ----------------------------------------------------------------------------
module clt_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  clt_pkg::t_in_word   i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output clt_pkg::t_in_word   o_word,
    output logic [4:0]          o_class
);
    // class bits: whitespace, digit, alpha, hex digit, ident char
    logic [7:0] b;
    logic [4:0] cls;
    logic       r_valid;
    clt_pkg::t_in_word r_word;
    logic [4:0] r_class;

    assign b = i_word.source_byte;
    always_comb begin
        cls[0] = (b == 8'h20) || (b >= 8'd9 && b <= 8'd13);
        cls[1] = (b >= "0" && b <= "9");
        cls[2] = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
        cls[3] = cls[1] || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
        cls[4] = cls[1] || cls[2] || (b == "_");
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;
    assign o_class = r_class;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_word  <= i_word;
            r_class <= cls;
        end
    end
endmodule

// File: hdl/clt_back.sv
// ----------------------------------------------------------------------------
// clt_back
// scanner fsm: one byte per cycle while not stalled, up to two tokens per byte
// ----------------------------------------------------------------------------
module clt_back #(
    parameter int KEYWORD_MAX_LEN = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  clt_pkg::t_in_word   i_word,
    input  logic [4:0]          i_class,
    output logic                o_valid,
    input  logic                i_ready,
    output clt_pkg::t_out_word  o_word
);
    localparam int KB = KEYWORD_MAX_LEN * 8;
    localparam int LW = $clog2(KEYWORD_MAX_LEN + 1);

    logic [3:0]                      r_mode, n_mode;
    logic [7:0]                      r_pop, n_pop;
    logic [63:0]                     r_acc, n_acc;
    logic                            r_ovf, n_ovf;
    logic [KB-1:0]                   r_kw, n_kw;
    logic [15:0]                     r_tlen, n_tlen;
    logic [15:0]                     r_tline, n_tline, r_tcol, n_tcol;
    logic [clt_pkg::OFFSET_BITS-1:0] r_toff, n_toff;
    logic [15:0]                     r_line, n_line, r_col, n_col;
    logic [clt_pkg::OFFSET_BITS-1:0] r_off, n_off;
    logic [7:0]                      r_lch, n_lch;

    // output queue of two words
    clt_pkg::t_out_word     r_q0, r_q1;
    logic [1:0]             r_cnt;
    clt_pkg::t_out_word     e0, e1;
    logic                   v0, v1;

    logic [7:0] b;
    logic       take;
    assign b = i_word.source_byte;
    assign o_ready = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_ready);
    assign take = i_valid && o_ready;

    function automatic clt_pkg::t_out_word mk(
        input logic [6:0] k, input logic [62:0] v, input logic [15:0] ln,
        input logic [15:0] cl, input logic [clt_pkg::OFFSET_BITS-1:0] of,
        input logic [15:0] len, input logic [2:0] er);
        clt_pkg::t_out_word w;
        w.token_kind    = k;
        w.token_value   = v;
        w.start_line    = ln;
        w.start_column  = cl;
        w.start_offset  = of;
        w.lexeme_length = len;
        w.error_code    = er;
        w.last_of_run   = 1'b0;
        return w;
    endfunction

    // keyword lookup over the first KEYWORD_MAX_LEN bytes
    logic [6:0] ident_kind;
    always_comb begin
        logic [63:0] t;
        logic [3:0]  kl;
        ident_kind = clt_pkg::K_IDENT;
        for (int i = clt_pkg::KW_COUNT - 1; i >= 0; i--) begin
            t  = clt_pkg::kw_text(i);
            kl = clt_pkg::kw_len(i);
            if (r_tlen == 16'(kl) && r_kw[KB-1 -: 64] == t) ident_kind = 7'(i);
        end
    end

    // next value acc * base + digit by shifts; overflow when it passes the max
    logic [3:0]  dig;
    logic        is16;
    logic [67:0] prod;
    logic        prod_ovf;
    always_comb begin
        dig  = i_class[1] ? 4'(b - "0") :
               (b >= "a" ? 4'(b - "a" + 8'd10) : 4'(b - "A" + 8'd10));
        is16 = (r_mode == clt_pkg::M_HEX);
        prod = (is16 ? {r_acc, 4'd0}
                     : ({1'b0, r_acc, 3'd0} + {3'd0, r_acc, 1'b0})) + 68'(dig);
        prod_ovf = (prod > {5'd0, clt_pkg::VALUE_MAX});
    end

    always_comb begin
        logic        fresh;
        logic [7:0]  so;
        clt_pkg::t_op_info oi;
        logic        is_end;
        n_mode = r_mode; n_pop = r_pop; n_acc = r_acc; n_ovf = r_ovf; n_kw = r_kw;
        n_tlen = r_tlen; n_tline = r_tline; n_tcol = r_tcol; n_toff = r_toff;
        n_line = r_line; n_col = r_col; n_off = r_off; n_lch = r_lch;
        e0 = '0; e1 = '0; v0 = 1'b0; v1 = 1'b0;
        fresh = 1'b0;
        is_end = i_word.kind;
        oi = clt_pkg::op_kinds(r_pop);
        so = clt_pkg::single_op(b);
        if (is_end) begin
            v0 = 1'b1;
            case (r_mode)
                clt_pkg::M_OPER:
                    e0 = mk(oi.alone, '0, r_tline, r_tcol, r_toff, r_tlen, 3'd0);
                clt_pkg::M_SLASH:
                    e0 = mk(clt_pkg::K_DIV, '0, r_tline, r_tcol, r_toff, r_tlen, 3'd0);
                clt_pkg::M_ZERO:
                    e0 = mk(clt_pkg::K_INT, '0, r_tline, r_tcol, r_toff, r_tlen, 3'd0);
                clt_pkg::M_DEC, clt_pkg::M_HEX:
                    e0 = r_ovf ? mk(clt_pkg::K_ERROR, '0, r_tline, r_tcol, r_toff, '0,
                                    clt_pkg::E_OVERFLOW)
                               : mk(clt_pkg::K_INT, r_acc[62:0], r_tline, r_tcol, r_toff,
                                    r_tlen, 3'd0);
                clt_pkg::M_IDENT:
                    e0 = mk(ident_kind, '0, r_tline, r_tcol, r_toff, r_tlen, 3'd0);
                clt_pkg::M_CH_OPEN, clt_pkg::M_CH_CLOSE:
                    e0 = mk(clt_pkg::K_ERROR, '0, r_tline, r_tcol, r_toff, '0,
                            clt_pkg::E_UNTERM);
                clt_pkg::M_CH_ESC:
                    e0 = mk(clt_pkg::K_ERROR, '0, r_line, r_col, r_off, '0,
                            clt_pkg::E_BAD_ESC);
                default: v0 = 1'b0;
            endcase
            if (v0) begin
                v1 = 1'b1;
                e1 = mk(clt_pkg::K_END, '0, r_line, r_col, r_off, '0, 3'd0);
            end else begin
                v0 = 1'b1;
                e0 = mk(clt_pkg::K_END, '0, r_line, r_col, r_off, '0, 3'd0);
            end
            n_mode = clt_pkg::M_IDLE; n_pop = '0; n_acc = '0; n_ovf = 1'b0; n_kw = '0;
            n_tlen = '0; n_tline = 16'd1; n_tcol = 16'd1; n_toff = '0;
            n_line = 16'd1; n_col = 16'd1; n_off = '0; n_lch = '0;
        end else begin
            case (r_mode)
                clt_pkg::M_IDLE: fresh = 1'b1;
                clt_pkg::M_OPER: begin
                    if (oi.has_dbl && b == r_pop) begin
                        v0 = 1; e0 = mk(oi.dbl, '0, r_tline, r_tcol, r_toff, 16'd2, 3'd0);
                        n_mode = clt_pkg::M_IDLE;
                    end else if (oi.has_eq && b == "=") begin
                        v0 = 1; e0 = mk(oi.eq, '0, r_tline, r_tcol, r_toff, 16'd2, 3'd0);
                        n_mode = clt_pkg::M_IDLE;
                    end else begin
                        v0 = 1; e0 = mk(oi.alone, '0, r_tline, r_tcol, r_toff, r_tlen, 3'd0);
                        fresh = 1'b1;
                    end
                end
                clt_pkg::M_SLASH: begin
                    if (b == "/") n_mode = clt_pkg::M_LINE;
                    else if (b == "*") n_mode = clt_pkg::M_BLOCK;
                    else if (b == "=") begin
                        v0 = 1; e0 = mk(clt_pkg::K_DIVEQ, '0, r_tline, r_tcol, r_toff, 16'd2,
                                        3'd0);
                        n_mode = clt_pkg::M_IDLE;
                    end else begin
                        v0 = 1; e0 = mk(clt_pkg::K_DIV, '0, r_tline, r_tcol, r_toff, r_tlen,
                                        3'd0);
                        fresh = 1'b1;
                    end
                end
                clt_pkg::M_LINE: if (b == 8'h0A) n_mode = clt_pkg::M_IDLE;
                clt_pkg::M_BLOCK: if (b == "*") n_mode = clt_pkg::M_BLOCK_STAR;
                clt_pkg::M_BLOCK_STAR: begin
                    if (b == "/") n_mode = clt_pkg::M_IDLE;
                    else if (b != "*") n_mode = clt_pkg::M_BLOCK;
                end
                clt_pkg::M_ZERO, clt_pkg::M_DEC, clt_pkg::M_HEX: begin
                    if (r_mode == clt_pkg::M_ZERO && (b == "x" || b == "X")) begin
                        n_tlen = 16'd2; n_mode = clt_pkg::M_HEX;
                    end else if ((r_mode != clt_pkg::M_HEX && i_class[1]) ||
                                 (r_mode == clt_pkg::M_HEX && i_class[3])) begin
                        n_mode = is16 ? clt_pkg::M_HEX : clt_pkg::M_DEC;
                        if (!r_ovf) begin
                            if (prod_ovf) n_ovf = 1'b1;
                            else n_acc = prod[63:0];
                        end
                        n_tlen = clt_pkg::inc16(r_tlen);
                    end else if (r_ovf) begin
                        v0 = 1; e0 = mk(clt_pkg::K_ERROR, '0, r_tline, r_tcol, r_toff, '0,
                                        clt_pkg::E_OVERFLOW);
                        n_mode = clt_pkg::M_HALT;
                    end else begin
                        v0 = 1; e0 = mk(clt_pkg::K_INT, r_acc[62:0], r_tline, r_tcol, r_toff,
                                        r_tlen, 3'd0);
                        fresh = 1'b1;
                    end
                end
                clt_pkg::M_IDENT: begin
                    if (i_class[4]) begin
                        if (r_tlen < 16'(KEYWORD_MAX_LEN))
                            n_kw[KB-1 - 8*r_tlen[LW-1:0] -: 8] = b;
                        n_tlen = clt_pkg::inc16(r_tlen);
                    end else begin
                        v0 = 1; e0 = mk(ident_kind, '0, r_tline, r_tcol, r_toff, r_tlen, 3'd0);
                        fresh = 1'b1;
                    end
                end
                clt_pkg::M_CH_OPEN: begin
                    if (b == "\\") begin
                        n_tlen = 16'd2; n_mode = clt_pkg::M_CH_ESC;
                    end else if (b == "'") begin
                        v0 = 1; e0 = mk(clt_pkg::K_ERROR, '0, r_tline, r_tcol, r_toff, '0,
                                        clt_pkg::E_EMPTY);
                        n_mode = clt_pkg::M_HALT;
                    end else begin
                        n_lch = b; n_tlen = 16'd2; n_mode = clt_pkg::M_CH_CLOSE;
                    end
                end
                clt_pkg::M_CH_ESC: begin
                    n_tlen = 16'd3; n_mode = clt_pkg::M_CH_CLOSE;
                    case (b)
                        "n":  n_lch = 8'h0A;
                        "t":  n_lch = 8'h09;
                        "r":  n_lch = 8'h0D;
                        "0":  n_lch = 8'h00;
                        "'":  n_lch = "'";
                        "\\": n_lch = "\\";
                        default: begin
                            v0 = 1; e0 = mk(clt_pkg::K_ERROR, '0, r_line, r_col, r_off, '0,
                                            clt_pkg::E_BAD_ESC);
                            n_mode = clt_pkg::M_HALT; n_tlen = r_tlen;
                        end
                    endcase
                end
                clt_pkg::M_CH_CLOSE: begin
                    v0 = 1;
                    if (b == "'") begin
                        e0 = mk(clt_pkg::K_CHAR, 63'(r_lch), r_tline, r_tcol, r_toff,
                                clt_pkg::inc16(r_tlen), 3'd0);
                        n_mode = clt_pkg::M_IDLE;
                    end else begin
                        e0 = mk(clt_pkg::K_ERROR, '0, r_tline, r_tcol, r_toff, '0,
                                clt_pkg::E_UNTERM);
                        n_mode = clt_pkg::M_HALT;
                    end
                end
                default: ;
            endcase
            // a new token starting on this byte; its result lands in slot 1
            if (fresh) begin
                n_mode = clt_pkg::M_IDLE;
                if (!i_class[0]) begin
                    n_tline = r_line; n_tcol = r_col; n_toff = r_off; n_tlen = 16'd1;
                    if (b == "/") n_mode = clt_pkg::M_SLASH;
                    else if (i_class[1]) begin
                        n_mode = (b == "0") ? clt_pkg::M_ZERO : clt_pkg::M_DEC;
                        n_acc = 64'(b - "0"); n_ovf = 1'b0;
                    end else if (b == "'") n_mode = clt_pkg::M_CH_OPEN;
                    else if (i_class[2] || b == "_") begin
                        n_mode = clt_pkg::M_IDENT;
                        n_kw = '0; n_kw[KB-1 -: 8] = b;
                    end else if (so[7]) begin
                        v1 = 1; e1 = mk(so[6:0], '0, r_line, r_col, r_off, 16'd1, 3'd0);
                    end else if (clt_pkg::op_kinds(b).is_op) begin
                        n_mode = clt_pkg::M_OPER; n_pop = b;
                    end else begin
                        v1 = 1; e1 = mk(clt_pkg::K_ERROR, '0, r_line, r_col, r_off, '0,
                                        clt_pkg::E_BAD_CHAR);
                        n_mode = clt_pkg::M_HALT; n_tlen = r_tlen;
                        n_tline = r_tline; n_tcol = r_tcol; n_toff = r_toff;
                    end
                end
            end
            if (r_off != {clt_pkg::OFFSET_BITS{1'b1}}) n_off = r_off + 1'b1;
            if (b == 8'h0A) begin
                n_line = clt_pkg::inc16(r_line); n_col = 16'd1;
            end else begin
                n_col = clt_pkg::inc16(r_col);
            end
        end
        // compact to slot 0 first and flag the last one
        if (!v0 && v1) begin
            e0 = e1; v0 = 1'b1; v1 = 1'b0;
        end
        if (v1) e1.last_of_run = 1'b1;
        else    e0.last_of_run = 1'b1;
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_word  = r_q0;

    always_ff @(posedge i_clk) begin
        logic [1:0] c;
        clt_pkg::t_out_word q0, q1;
        c  = r_cnt;
        q0 = r_q0;
        q1 = r_q1;
        if (!i_rst_n) begin
            r_mode <= clt_pkg::M_IDLE; r_pop <= '0; r_acc <= '0; r_ovf <= 1'b0;
            r_kw <= '0; r_tlen <= '0; r_tline <= 16'd1; r_tcol <= 16'd1; r_toff <= '0;
            r_line <= 16'd1; r_col <= 16'd1; r_off <= '0; r_lch <= '0;
            r_cnt <= 2'd0;
        end else begin
            if (o_valid && i_ready) begin
                q0 = q1;
                c = c - 2'd1;
            end
            if (take) begin
                r_mode <= n_mode; r_pop <= n_pop; r_acc <= n_acc; r_ovf <= n_ovf;
                r_kw <= n_kw; r_tlen <= n_tlen; r_tline <= n_tline; r_tcol <= n_tcol;
                r_toff <= n_toff; r_line <= n_line; r_col <= n_col; r_off <= n_off;
                r_lch <= n_lch;
                if (v0) begin
                    if (c == 2'd0) begin
                        q0 = e0;
                        if (v1) q1 = e1;
                    end else begin
                        q1 = e0;
                    end
                    c = c + (v1 ? 2'd2 : 2'd1);
                end
            end
            r_q0  <= q0;
            r_q1  <= q1;
            r_cnt <= c;
        end
    end
endmodule

// File: hdl/c_like_source_tokenizer.sv
// ----------------------------------------------------------------------------
// c_like_source_tokenizer
// streaming lexer for a small c-like language, one source byte per word
// ----------------------------------------------------------------------------
//  channel | direction | payload                | handshake
//  input   | in        | kind, source_byte      | i_in_valid / o_in_ready
//  output  | out       | token word             | o_out_valid / i_out_ready
//
// one byte per cycle sustained while each byte yields at most one token and the
// output is ready; a byte enters the classifier register, then the scanner,
// which emits zero to two tokens into a two-word output queue from which each
// token is offered in turn. the scanner stalls while that queue cannot take a full
// pair, so a byte with two tokens fills it and holds the scanner until a word
// leaves. reset returns the scanner to the start of a new source.
module c_like_source_tokenizer #(
    parameter int KEYWORD_MAX_LEN = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  clt_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output clt_pkg::t_out_word  o_out_word
);
    // front to back link
    logic              f_valid, b_ready;
    clt_pkg::t_in_word f_word;
    logic [4:0]        f_class;

    // classify the byte
    clt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_word  (i_in_word),
        .o_valid (f_valid),
        .i_ready (b_ready),
        .o_word  (f_word),
        .o_class (f_class)
    );

    // scan and emit tokens
    clt_back #(
        .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (b_ready),
        .i_word  (f_word),
        .i_class (f_class),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

    // an error word never reports a length
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.token_kind == clt_pkg::K_ERROR)
            |-> o_out_word.lexeme_length == 16'd0)
        else $error("error word with length");

    // an end word closes its run
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.token_kind == clt_pkg::K_END)
            |-> o_out_word.last_of_run)
        else $error("end word not last of run");

    // non-error words carry no error code
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.token_kind != clt_pkg::K_ERROR)
            |-> o_out_word.error_code == 3'd0)
        else $error("stray error code");
endmodule
